// ===== src/a429_pkg.sv =====
// Shared types, constants and the parity function for the ARINC 429 transmitter.
// No dependencies.
package a429_pkg;

   localparam int PERIOD_W     = 16;
   localparam int COUNT_W      = 20;
   localparam int WORD_BITS    = 32;
   localparam int BIDX_W       = 5;
   localparam int GAP_MUL_W    = 4;
   localparam int GAP_BITS_DEF = 10;
   localparam int BODY_W       = WORD_BITS - 1;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd80;
   localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 16'd2;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_GAP  = 2'd1,
      PH_BITS = 2'd2
   } phase_type;

   typedef struct packed {
      logic line_a;
      logic line_b;
      logic busy_res;
      logic word_done;
      logic load_accepted;
   } rsp_type;

   // body plus bit 31 chosen for odd parity, optionally flipped
   function automatic logic [WORD_BITS-1:0] odd_parity_word(
      input logic [BODY_W-1:0] body,
      input logic              inject
   );
      logic par;
      par = ~(^body) ^ inject;
      return {par, body};
   endfunction

endpackage

// ===== src/a429_cfg.sv =====
// Bit period register and precomputed gap length for the ARINC 429 transmitter.
// Depends on a429_pkg.
module a429_cfg #(
   parameter int GAP_BITS = a429_pkg::GAP_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic [a429_pkg::PERIOD_W-1:0]     csr_wdata,
   output logic [a429_pkg::PERIOD_W-1:0]     period,
   output logic [a429_pkg::COUNT_W-1:0]      gap_end
);

   localparam logic [a429_pkg::GAP_MUL_W-1:0] GAP_MUL = a429_pkg::GAP_MUL_W'(GAP_BITS);
   localparam logic [a429_pkg::COUNT_W-1:0] GAP_END_RESET =
      a429_pkg::COUNT_W'(int'(a429_pkg::PERIOD_RESET) * GAP_BITS);

   logic [a429_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic [a429_pkg::COUNT_W-1:0]  gap_end_ff, gap_end_in;

   always_comb begin
      // periods below two count as two
      period_in  = (csr_wdata < a429_pkg::PERIOD_MIN) ? a429_pkg::PERIOD_MIN : csr_wdata;
      gap_end_in = {{a429_pkg::GAP_MUL_W{1'b0}}, period_in} *
                   {{a429_pkg::PERIOD_W{1'b0}}, GAP_MUL};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= a429_pkg::PERIOD_RESET;
         gap_end_ff <= GAP_END_RESET;
      end else if (csr_wen) begin
         period_ff  <= period_in;
         gap_end_ff <= gap_end_in;
      end
   end

   assign period  = period_ff;
   assign gap_end = gap_end_ff;

endmodule

// ===== src/a429_seq.sv =====
// Word sequencer: gap and bit timing, shift word and line levels per sample.
// Depends on a429_pkg.
module a429_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic                                req_load,
   input  logic [a429_pkg::BODY_W-1:0]         payload,
   input  logic                                parity_error,
   input  logic [a429_pkg::PERIOD_W-1:0]       period,
   input  logic [a429_pkg::COUNT_W-1:0]        gap_end,
   output a429_pkg::rsp_type                   result
);

   a429_pkg::phase_type                  phase_ff, phase_in;
   logic [a429_pkg::WORD_BITS-1:0]       shift_word_ff, shift_word_in;
   logic [a429_pkg::COUNT_W-1:0]         count_ff, count_in;
   logic [a429_pkg::BIDX_W-1:0]          bit_idx_ff, bit_idx_in;

   logic [a429_pkg::COUNT_W:0]           count_inc;
   logic [a429_pkg::COUNT_W-1:0]         half;
   logic                                 cur_bit;

   always_comb begin
      count_inc     = {1'b0, count_ff} + 1'b1;
      half          = a429_pkg::COUNT_W'(period >> 1);
      cur_bit       = shift_word_ff[bit_idx_ff];
      phase_in      = phase_ff;
      shift_word_in = shift_word_ff;
      count_in      = count_ff;
      bit_idx_in    = bit_idx_ff;
      result        = '0;

      if (req_load) begin
         result.busy_res = 1'b1;
         if (phase_ff != a429_pkg::PH_GAP && phase_ff != a429_pkg::PH_BITS) begin
            shift_word_in = a429_pkg::odd_parity_word(payload, parity_error);
            phase_in      = a429_pkg::PH_GAP;
            count_in      = '0;
            bit_idx_in    = '0;
            result.load_accepted = 1'b1;
         end
      end else begin
         unique case (phase_ff)
            a429_pkg::PH_GAP: begin
               result.busy_res = 1'b1;
               if (count_inc >= {1'b0, gap_end}) begin
                  phase_in   = a429_pkg::PH_BITS;
                  count_in   = '0;
                  bit_idx_in = '0;
               end else begin
                  count_in = count_inc[a429_pkg::COUNT_W-1:0];
               end
            end
            a429_pkg::PH_BITS: begin
               result.busy_res = 1'b1;
               if (count_ff < half) begin
                  result.line_a = cur_bit;
                  result.line_b = ~cur_bit;
               end
               if (count_inc >= {{(a429_pkg::COUNT_W + 1 - a429_pkg::PERIOD_W){1'b0}}, period})
               begin
                  count_in = '0;
                  if (bit_idx_ff == a429_pkg::BIDX_W'(a429_pkg::WORD_BITS - 1)) begin
                     result.word_done = 1'b1;
                     phase_in         = a429_pkg::PH_IDLE;
                     bit_idx_in       = '0;
                  end else begin
                     bit_idx_in = bit_idx_ff + 1'b1;
                  end
               end else begin
                  count_in = count_inc[a429_pkg::COUNT_W-1:0];
               end
            end
            default: begin
               phase_in = a429_pkg::PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= a429_pkg::PH_IDLE;
         shift_word_ff <= '0;
         count_ff      <= '0;
         bit_idx_ff    <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         shift_word_ff <= shift_word_in;
         count_ff      <= count_in;
         bit_idx_ff    <= bit_idx_in;
      end
   end

endmodule

// ===== src/arinc429_bipolar_rz_transmitter.sv =====
// ARINC 429 bipolar return-to-zero transmitter, one line sample per tick transfer.
// The result of a transfer is registered and presented in the cycle after it is accepted.
// Throughput: one item per clock while rsp_tready holds; the result register lets a new transfer in
// while the previous result is being taken.
// Reset (synchronous, active high): idle, result channel empty, period 80.
// Depends on a429_pkg, a429_cfg and a429_seq.
module arinc429_bipolar_rz_transmitter #(
   parameter int GAP_BITS = a429_pkg::GAP_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [30:0] payload, [31] parity_error
   input  logic        req_tuser,   // [0] req_type: 1 = load, 0 = tick
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] line_a, [1] line_b, [2] busy_res, [3] load_accepted
   output logic        rsp_tlast,   // word_done
   input  logic        csr_wen,
   input  logic [15:0] csr_wdata
);

   logic [a429_pkg::PERIOD_W-1:0] period;
   logic [a429_pkg::COUNT_W-1:0]  gap_end;
   logic                          step;
   a429_pkg::rsp_type             result;
   a429_pkg::rsp_type             rsp_ff;
   logic                          rsp_valid_ff, rsp_valid_in;

   a429_cfg #(
      .GAP_BITS (GAP_BITS)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .period    (period),
      .gap_end   (gap_end)
   );

   a429_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .req_load     (req_tuser),
      .payload      (req_tdata[a429_pkg::BODY_W-1:0]),
      .parity_error (req_tdata[a429_pkg::BODY_W]),
      .period       (period),
      .gap_end      (gap_end),
      .result       (result)
   );

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign step       = req_tvalid & req_tready;

   always_comb begin
      rsp_valid_in = step | (rsp_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_ff.load_accepted, rsp_ff.busy_res,
                        rsp_ff.line_b, rsp_ff.line_a};
   assign rsp_tlast  = rsp_ff.word_done;

endmodule
